>>> rtl/core/vpd_pkg.sv
`timescale 1ns / 1ps

package vpd_pkg;

    // configuration register file
    localparam int CFG_W      = 11;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register index, taken from paddr[2]
    localparam logic REG_FRAME_COLUMNS = 1'b0;
    localparam logic REG_FRAME_ROWS    = 1'b1;

    localparam logic [CFG_W-1:0] FRAME_COLUMNS_RST = 11'd4;
    localparam logic [CFG_W-1:0] FRAME_ROWS_RST    = 11'd5;

    // defaults for the top level parameters
    localparam int DEF_MAX_COLUMNS = 1024;
    localparam int DEF_MAX_ROWS    = 1024;
    localparam int DEF_VALUE_WIDTH = 16;

    // smallest frame side that still holds one window
    localparam int MIN_SIDE = 3;

endpackage

>>> rtl/core/vpd_line_store.sv
`timescale 1ns / 1ps

module vpd_line_store #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/vpd_window.sv
`timescale 1ns / 1ps

module vpd_window #(
    parameter int VW = 16,
    parameter int CW = 10,
    parameter int RW = 10
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 has_result,
    input  logic [RW-1:0]        row,
    input  logic [CW-1:0]        col,
    input  logic signed [VW-1:0] above2,
    input  logic signed [VW-1:0] above1,
    input  logic signed [VW-1:0] value,
    output logic                 take,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [RW-1:0]        centre_row,
    output logic [CW-1:0]        centre_column,
    output logic signed [VW-1:0] centre_value,
    output logic                 is_valley
);

    // window cells, [column][row], column 0 the oldest
    logic signed [VW-1:0] win_reg  [3][3];
    logic signed [VW-1:0] win_next [3][3];

    logic                 valid_reg;
    logic                 valid_next;
    logic [RW-1:0]        row_reg;
    logic [CW-1:0]        col_reg;
    logic signed [VW-1:0] centre_reg;
    logic                 valley_reg;
    logic                 valley_next;

    // shift in the new column
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            win_next[0][r] = win_reg[1][r];
            win_next[1][r] = win_reg[2][r];
        end
        win_next[2][0] = above2;
        win_next[2][1] = above1;
        win_next[2][2] = value;
    end

    // all eight neighbors strictly above the centre
    always_comb
    begin
        valley_next = 1'b1;
        for (int c = 0; c < 3; c++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                if (!(c == 1 && r == 1) && (win_next[c][r] <= win_next[1][1]))
                begin
                    valley_next = 1'b0;
                end
            end
        end
    end

    assign take = !valid_reg || out_ready;

    // output word valid
    always_comb
    begin
        valid_next = valid_reg;
        if (adv)
        begin
            valid_next = has_result;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // window and result payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            win_reg    <= win_next;
            row_reg    <= row - RW'(1);
            col_reg    <= col - CW'(1);
            centre_reg <= win_next[1][1];
            valley_reg <= valley_next;
        end
    end

    assign out_valid     = valid_reg;
    assign centre_row    = row_reg;
    assign centre_column = col_reg;
    assign centre_value  = centre_reg;
    assign is_valley     = valley_reg;

endmodule

>>> rtl/core/valley_point_detector_3x3_top.sv
`timescale 1ns / 1ps

// channel | dir | signals                          | word
// --------+-----+----------------------------------+-------------------------------------
// s_*     | in  | s_tvalid s_tready s_tdata        | element_value
// m_*     | out | m_tvalid m_tready m_tdata m_tuser| centre_row, centre_column,
//         |     |                                  | centre_value; tuser is_valley
// apb     | in  | psel penable pwrite paddr pwdata | frame_columns @0x0, frame_rows @0x4
//
// one element per cycle sustained unless the output stalls; a result passes the element stage, then the window
// the line store read is registered, its write-back happens as the element leaves the element stage
// reset clears the position counters and the pipeline valids; line stores are
// not cleared, entries read before their first write only feed rows with no result
// a stalled output stalls the element stage, which stalls s_tready

module valley_point_detector_3x3_top #(
    parameter int MAX_COLUMNS = vpd_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = vpd_pkg::DEF_MAX_ROWS,
    parameter int VALUE_WIDTH = vpd_pkg::DEF_VALUE_WIDTH
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // element_value
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0]      s_tdata,
    // centre_row, centre_column, centre_value
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [(($clog2(MAX_ROWS)+$clog2(MAX_COLUMNS)+VALUE_WIDTH+7)/8)*8-1:0] m_tdata,
    // is_valley
    output logic                                  m_tuser,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [vpd_pkg::APB_ADDR_W-1:0]        paddr,
    input  logic [vpd_pkg::APB_DATA_W-1:0]        pwdata,
    output logic [vpd_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                  pready
);

    import vpd_pkg::*;

    localparam int VW    = VALUE_WIDTH;
    localparam int CW    = $clog2(MAX_COLUMNS);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CCW   = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
    localparam int RCW   = (RW + 1 > CFG_W) ? RW + 1 : CFG_W;
    localparam int MBITS = RW + CW + VW;
    localparam int MDW   = ((MBITS + 7) / 8) * 8;

    logic [CFG_W-1:0] frame_columns_reg;
    logic [CFG_W-1:0] frame_rows_reg;

    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic [RW-1:0] row_reg;
    logic [RW-1:0] row_next;

    logic           s1_valid_reg;
    logic           s1_valid_next;
    logic [CW-1:0]  s1_col_reg;
    logic [RW-1:0]  s1_row_reg;
    logic [VW-1:0]  s1_value_reg;

    logic           s_accept;
    logic           s1_adv;
    logic           take;
    logic           has_result;
    logic           cfg_wr;

    logic [CCW-1:0] cols_cfg;
    logic [CCW-1:0] cols_eff;
    logic [RCW-1:0] rows_cfg;
    logic [RCW-1:0] rows_eff;
    logic           col_last;
    logic           row_last;

    logic [2*VW-1:0] ls_rd_data;
    logic [2*VW-1:0] ls_wr_data;

    logic [RW-1:0]        out_row;
    logic [CW-1:0]        out_col;
    logic signed [VW-1:0] out_value;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_columns_reg <= FRAME_COLUMNS_RST;
            frame_rows_reg    <= FRAME_ROWS_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_FRAME_COLUMNS: frame_columns_reg <= pwdata[CFG_W-1:0];
                REG_FRAME_ROWS:    frame_rows_reg    <= pwdata[CFG_W-1:0];
                default:           frame_rows_reg    <= frame_rows_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_FRAME_COLUMNS: prdata = APB_DATA_W'(frame_columns_reg);
            REG_FRAME_ROWS:    prdata = APB_DATA_W'(frame_rows_reg);
            default:           prdata = '0;
        endcase
    end

    // frame size saturated to the supported range
    assign cols_cfg = CCW'(frame_columns_reg);
    assign rows_cfg = RCW'(frame_rows_reg);

    always_comb
    begin
        if (cols_cfg < CCW'(MIN_SIDE))
        begin
            cols_eff = CCW'(MIN_SIDE);
        end
        else if (cols_cfg > CCW'(MAX_COLUMNS))
        begin
            cols_eff = CCW'(MAX_COLUMNS);
        end
        else
        begin
            cols_eff = cols_cfg;
        end

        if (rows_cfg < RCW'(MIN_SIDE))
        begin
            rows_eff = RCW'(MIN_SIDE);
        end
        else if (rows_cfg > RCW'(MAX_ROWS))
        begin
            rows_eff = RCW'(MAX_ROWS);
        end
        else
        begin
            rows_eff = rows_cfg;
        end
    end

    // position counters, wrap at the end of a row and of a frame
    assign col_last = (CCW'(col_reg) + CCW'(1)) >= cols_eff;
    assign row_last = (RCW'(row_reg) + RCW'(1)) >= rows_eff;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (s_accept)
        begin
            if (col_last)
            begin
                col_next = '0;
                row_next = row_last ? '0 : row_reg + RW'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // element stage, aligned with the line store read data
    assign s1_adv   = s1_valid_reg && take;
    assign s_tready = !s1_valid_reg || s1_adv;
    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_col_reg   <= col_reg;
            s1_row_reg   <= row_reg;
            s1_value_reg <= s_tdata[VW-1:0];
        end
    end

    // line store pair: upper half row r-2, lower half row r-1
    assign ls_wr_data = {ls_rd_data[VW-1:0], s1_value_reg};

    vpd_line_store #(
        .DEPTH (MAX_COLUMNS),
        .WIDTH (2 * VW)
    ) u_line_store (
        .clk     (clk),
        .rd_en   (s_accept),
        .rd_addr (col_reg),
        .rd_data (ls_rd_data),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data (ls_wr_data)
    );

    // a full window exists from row 2, column 2 on
    assign has_result = (s1_row_reg >= RW'(2)) && (s1_col_reg >= CW'(2));

    vpd_window #(
        .VW (VW),
        .CW (CW),
        .RW (RW)
    ) u_window (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (s1_adv),
        .has_result    (has_result),
        .row           (s1_row_reg),
        .col           (s1_col_reg),
        .above2        (ls_rd_data[2*VW-1:VW]),
        .above1        (ls_rd_data[VW-1:0]),
        .value         (s1_value_reg),
        .take          (take),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .centre_row    (out_row),
        .centre_column (out_col),
        .centre_value  (out_value),
        .is_valley     (m_tuser)
    );

    assign m_tdata = MDW'({out_value, out_col, out_row});

`ifndef SYNTHESIS
    // element with no full window never produces a word
    a_no_border_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && !has_result) |=> !m_tvalid)
        else $error("result produced for an incomplete window");

    // input is held off only behind a stalled element and output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (s1_valid_reg && m_tvalid && !m_tready))
        else $error("input stalled without a full pipeline");

    // accepted element lands in the element stage
    a_accept_stage: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> s1_valid_reg)
        else $error("accepted element lost");

    // reported centre never lies on the top or left border
    a_centre_inside: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_row != '0 && out_col != '0))
        else $error("centre on the frame border");
`endif

endmodule
